FILE: hdl/prs_pkg.sv
`default_nettype none

package prs_pkg;

   localparam int DEF_MAX_ELEMENTS = 64;

   localparam int SIZE_W  = 7;
   localparam int INDEX_W = 6;
   localparam int DATA_W  = 32;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
   localparam logic [SIZE_W-1:0] PICK_RESET = 7'd64;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_RANDOM  = 2'd1,
      ACT_READ    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      RSP_LOADED    = 3'd0,
      RSP_SWAPPED   = 3'd1,
      RSP_REJECTED  = 3'd2,
      RSP_IDLE      = 3'd3,
      RSP_READ      = 3'd4,
      RSP_RESTARTED = 3'd5
   } status_type;

   typedef enum logic {
      REG_SIZE_IN_USE = 1'b0,
      REG_PICK_COUNT  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_WR_A,
      S_WR_B,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic wr_a;
      logic wr_b;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic swap;
   } flags_type;

endpackage

`default_nettype wire

FILE: hdl/prs_ctrl.sv
`default_nettype none

module prs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire prs_pkg::flags_type flags,
   output prs_pkg::cmd_type        cmd
);

   prs_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == prs_pkg::S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prs_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = prs_pkg::S_EVAL;
            end
         end
         prs_pkg::S_EVAL: begin
            state_in = flags.swap ? prs_pkg::S_WR_A : prs_pkg::S_FINISH;
         end
         prs_pkg::S_WR_A: begin
            state_in = prs_pkg::S_WR_B;
         end
         prs_pkg::S_WR_B: begin
            state_in = prs_pkg::S_FINISH;
         end
         prs_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = prs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = prs_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         prs_pkg::S_IDLE:   cmd.capture  = req_tvalid;
         prs_pkg::S_EVAL:   cmd.eval     = 1'b1;
         prs_pkg::S_WR_A:   cmd.wr_a     = 1'b1;
         prs_pkg::S_WR_B:   cmd.wr_b     = 1'b1;
         prs_pkg::S_FINISH: cmd.load_out = out_free;
         default:           cmd          = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prs_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/prs_datapath.sv
`default_nettype none

module prs_datapath #(
   parameter int MAX_ELEMENTS = prs_pkg::DEF_MAX_ELEMENTS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire prs_pkg::cmd_type                   cmd,
   output prs_pkg::flags_type                      flags,
   input  wire logic [1:0]                         req_action,
   input  wire logic [prs_pkg::INDEX_W-1:0]        req_index,
   input  wire logic signed [prs_pkg::DATA_W-1:0]  req_value,
   input  wire logic [prs_pkg::DATA_W-1:0]         req_word,
   input  wire logic                               csr_we,
   input  wire logic                               csr_index,
   input  wire logic [prs_pkg::SIZE_W-1:0]         csr_wdata,
   output logic [2:0]                              rsp_status,
   output logic signed [prs_pkg::DATA_W-1:0]       rsp_read_value,
   output logic [prs_pkg::SIZE_W-1:0]              rsp_step_position,
   output logic                                    rsp_shuffle_done
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int SW = prs_pkg::SIZE_W;
   localparam int IW = prs_pkg::INDEX_W;
   localparam int DW = prs_pkg::DATA_W;

   logic [DW-1:0] mem [MAX_ELEMENTS];

   logic [SW-1:0]         size_ff, pick_ff;
   logic [SW-1:0]         step_ff, step_in;
   prs_pkg::action_type   action_ff;
   logic [IW-1:0]         idx_ff;
   logic [DW-1:0]         value_ff;
   logic [SW-1:0]         word_ff;
   prs_pkg::status_type   status_ff, status_in;
   logic                  idx_ok_ff;
   logic [AW-1:0]         addr_a_ff, addr_b_ff;
   logic [DW-1:0]         rda_ff, rdb_ff;

   logic [SW-1:0] eff_size, cnt, steps, limit, mask, pick_v, pos_b;
   logic          idx_ok, swap;
   logic [AW+SW-1:0] step_ext, b_ext;
   logic [AW+IW-1:0] idx_ext;
   logic [AW-1:0]    step_addr, b_addr, idx_addr;
   logic [AW-1:0]    raddr_a, raddr_b, waddr;
   logic [DW-1:0]    wdata;
   logic             we, re;

   always_comb begin
      eff_size = (32'(size_ff) > 32'(MAX_ELEMENTS)) ? SW'(MAX_ELEMENTS) : size_ff;
      cnt      = (pick_ff > eff_size) ? eff_size : pick_ff;
      if (cnt < SW'(2)) begin
         steps = '0;
      end else if (cnt == eff_size) begin
         steps = cnt - SW'(1);
      end else begin
         steps = cnt;
      end
      limit  = eff_size - step_ff;
      mask   = limit - SW'(1);
      mask   = mask | (mask >> 1);
      mask   = mask | (mask >> 2);
      mask   = mask | (mask >> 4);
      pick_v = word_ff & mask;
      pos_b  = step_ff + pick_v;
   end

   assign idx_ok    = 32'(idx_ff) < 32'(MAX_ELEMENTS);
   assign step_ext  = {{AW{1'b0}}, step_ff};
   assign b_ext     = {{AW{1'b0}}, pos_b};
   assign idx_ext   = {{AW{1'b0}}, idx_ff};
   assign step_addr = step_ext[AW-1:0];
   assign b_addr    = b_ext[AW-1:0];
   assign idx_addr  = idx_ext[AW-1:0];

   always_comb begin
      status_in = status_ff;
      step_in   = step_ff;
      swap      = 1'b0;
      unique case (action_ff)
         prs_pkg::ACT_LOAD: begin
            status_in = prs_pkg::RSP_LOADED;
         end
         prs_pkg::ACT_RANDOM: begin
            if (step_ff >= steps) begin
               status_in = prs_pkg::RSP_IDLE;
            end else if (pick_v >= limit) begin
               status_in = prs_pkg::RSP_REJECTED;
            end else begin
               status_in = prs_pkg::RSP_SWAPPED;
               step_in   = step_ff + SW'(1);
               swap      = 1'b1;
            end
         end
         prs_pkg::ACT_READ: begin
            status_in = prs_pkg::RSP_READ;
         end
         prs_pkg::ACT_RESTART: begin
            status_in = prs_pkg::RSP_RESTARTED;
            step_in   = '0;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   assign flags.swap = swap;

   // eval reads both swap partners, or the read index on port a
   assign re      = cmd.eval;
   assign raddr_a = (action_ff == prs_pkg::ACT_READ) ? idx_addr : step_addr;
   assign raddr_b = b_addr;

   always_comb begin
      we    = 1'b0;
      waddr = idx_addr;
      wdata = value_ff;
      if (cmd.wr_a) begin
         we    = 1'b1;
         waddr = addr_a_ff;
         wdata = rdb_ff;
      end else if (cmd.wr_b) begin
         we    = 1'b1;
         waddr = addr_b_ff;
         wdata = rda_ff;
      end else if (cmd.eval && action_ff == prs_pkg::ACT_LOAD && idx_ok) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rda_ff <= mem[raddr_a];
         rdb_ff <= mem[raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= prs_pkg::action_type'(req_action);
         idx_ff    <= req_index;
         value_ff  <= req_value;
         word_ff   <= req_word[SW-1:0];
      end
      if (cmd.eval) begin
         status_ff <= status_in;
         idx_ok_ff <= idx_ok;
         addr_a_ff <= step_addr;
         addr_b_ff <= b_addr;
      end
      if (cmd.load_out) begin
         rsp_status        <= status_ff;
         rsp_read_value    <= (status_ff == prs_pkg::RSP_READ && idx_ok_ff) ?
                              rda_ff : '0;
         rsp_step_position <= step_ff;
         rsp_shuffle_done  <= (step_ff >= steps);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= prs_pkg::SIZE_RESET;
         pick_ff <= prs_pkg::PICK_RESET;
         step_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (prs_pkg::reg_index_type'(csr_index))
               prs_pkg::REG_SIZE_IN_USE: size_ff <= csr_wdata;
               prs_pkg::REG_PICK_COUNT:  pick_ff <= csr_wdata;
               default:                  size_ff <= size_ff;
            endcase
         end
         if (cmd.eval) begin
            step_ff <= step_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/partial_random_shuffle.sv
`default_nettype none

// Partial random shuffle over an internal store of MAX_ELEMENTS 32-bit
// words. Requests load or read an element by index, supply one random word
// for one swap attempt, or restart the step counter; every request yields
// exactly one response. One request is in work at a time: load, read,
// rejected, idle and restart requests pass the eval and finish states, an
// accepted swap also a write state per partner, as the element memory has a
// single write port (two reads in one cycle, then one write per partner).
// A finished response waits in an output register while the next request is
// taken. Elements must be loaded before they are read or swapped.
module partial_random_shuffle #(
   parameter int MAX_ELEMENTS = prs_pkg::DEF_MAX_ELEMENTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // index[5:0], value[37:6], random_word[69:38]
   input  wire logic [1:0]  req_tuser,  // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // read_value[31:0], step_position[38:32],
                                        // shuffle_done[39]
   output logic [2:0]       rsp_tuser,  // status[2:0]
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_wdata
);

   prs_pkg::cmd_type   cmd;
   prs_pkg::flags_type flags;

   logic signed [31:0] read_value;
   logic [6:0]         step_position;
   logic               shuffle_done;

   prs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   prs_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flags             (flags),
      .req_action        (req_tuser),
      .req_index         (req_tdata[5:0]),
      .req_value         (req_tdata[37:6]),
      .req_word          (req_tdata[69:38]),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_tuser),
      .rsp_read_value    (read_value),
      .rsp_step_position (step_position),
      .rsp_shuffle_done  (shuffle_done)
   );

   assign rsp_tdata = {shuffle_done, step_position, read_value};

`ifndef SYNTHESIS
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   a_swap_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == prs_pkg::RSP_SWAPPED |-> rsp_tdata[38:32] != 7'd0)
      else $error("swap response with step position zero");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == prs_pkg::RSP_RESTARTED |-> rsp_tdata[38:32] == 7'd0)
      else $error("restart response with nonzero step position");

   a_read_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != prs_pkg::RSP_READ |-> rsp_tdata[31:0] == 32'd0)
      else $error("read value nonzero on a non-read response");
`endif

endmodule

`default_nettype wire

FILE: sim/partial_random_shuffle_test.sv
`timescale 1ns / 1ps

module partial_random_shuffle_test;

   localparam int STORE_DEPTH    = prs_pkg::DEF_MAX_ELEMENTS;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PHASE_REQUESTS = 200;

   typedef struct packed {
      prs_pkg::status_type status;
      logic [31:0]         read_value;
      logic [6:0]          step_position;
      logic                shuffle_done;
   } shuffle_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // index[5:0], value[37:6], random_word[69:38]
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_value[31:0], step_position[38:32], shuffle_done[39]
   logic [2:0]  rsp_tuser;        // status[2:0]
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_wdata = '0;

   // mirror of the block
   logic [31:0]     element_mirror [STORE_DEPTH];
   int unsigned     step_mirror = 0;
   logic [6:0]      size_mirror = prs_pkg::SIZE_RESET;
   logic [6:0]      pick_mirror = prs_pkg::PICK_RESET;
   shuffle_rsp_type pending_responses [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int requests_sent = 0;
   int csr_writes    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;
   int status_seen [6];

   partial_random_shuffle uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned active_size();
      return (size_mirror > STORE_DEPTH) ? STORE_DEPTH : size_mirror;
   endfunction

   function automatic int unsigned steps_required();
      int unsigned span;
      int unsigned picks;
      span  = active_size();
      picks = (pick_mirror > span) ? span : pick_mirror;
      if (picks < 2) return 0;
      if (picks == span) return picks - 1;
      return picks;
   endfunction

   function automatic logic shuffle_finished();
      return step_mirror >= steps_required();
   endfunction

   function automatic shuffle_rsp_type predict_shuffle(prs_pkg::action_type act,
                                                       logic [5:0] idx, logic [31:0] val,
                                                       logic [31:0] word);
      shuffle_rsp_type rsp;
      logic [31:0]     limit;
      logic [31:0]     mask;
      logic [31:0]     offset;
      logic [31:0]     held;
      int unsigned     a;
      int unsigned     b;
      rsp = '0;
      case (act)
         prs_pkg::ACT_LOAD: begin
            element_mirror[idx] = val;
            rsp.status = prs_pkg::RSP_LOADED;
         end
         prs_pkg::ACT_RANDOM: begin
            if (shuffle_finished()) begin
               rsp.status = prs_pkg::RSP_IDLE;
            end else begin
               limit = active_size() - step_mirror;
               mask = limit - 1;
               mask |= mask >> 1;
               mask |= mask >> 2;
               mask |= mask >> 4;
               mask |= mask >> 8;
               mask |= mask >> 16;
               offset = word & mask;
               if (offset >= limit) begin
                  rsp.status = prs_pkg::RSP_REJECTED;
               end else begin
                  a = step_mirror;
                  b = step_mirror + offset;
                  held = element_mirror[a];
                  element_mirror[a] = element_mirror[b];
                  element_mirror[b] = held;
                  step_mirror++;
                  rsp.status = prs_pkg::RSP_SWAPPED;
               end
            end
         end
         prs_pkg::ACT_READ: begin
            rsp.read_value = element_mirror[idx];
            rsp.status = prs_pkg::RSP_READ;
         end
         default: begin
            step_mirror = 0;
            rsp.status = prs_pkg::RSP_RESTARTED;
         end
      endcase
      rsp.step_position = step_mirror[6:0];
      rsp.shuffle_done  = shuffle_finished();
      return rsp;
   endfunction

   // one request; valid is left high so back-to-back requests need no gap
   task automatic send_request(prs_pkg::action_type act, logic [5:0] idx, logic [31:0] val,
                               logic [31:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, word, val, idx};
      pending_responses.push_back(predict_shuffle(act, idx, val, word));
      requests_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(prs_pkg::reg_index_type idx, logic [6:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == prs_pkg::REG_SIZE_IN_USE) size_mirror = data;
      else pick_mirror = data;
      csr_writes++;
   endtask

   task automatic set_shuffle_config(logic [6:0] size, logic [6:0] pick);
      drain_responses();
      write_csr(prs_pkg::REG_SIZE_IN_USE, size);
      write_csr(prs_pkg::REG_PICK_COUNT, pick);
      csr_we <= 1'b0;
   endtask

   task automatic send_noise();
      send_request(prs_pkg::action_type'($urandom_range(3)), 6'($urandom_range(63)),
                   $urandom(), $urandom());
   endtask

   task automatic pick_random_config();
      case ($urandom_range(9))
         0: set_shuffle_config(7'd64, 7'd64);
         1: set_shuffle_config(7'd127, 7'($urandom_range(127)));
         2: set_shuffle_config(7'($urandom_range(1)), 7'($urandom_range(127)));
         3: set_shuffle_config(7'($urandom_range(2, 64)), 7'($urandom_range(1)));
         default: set_shuffle_config(7'($urandom_range(2, 12)), 7'($urandom_range(14)));
      endcase
   endtask

   task automatic test_fill_store();
      logic [31:0] v;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         case (i)
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom();
         endcase
         send_request(prs_pkg::ACT_LOAD, 6'(i), v, $urandom());
      end
      send_request(prs_pkg::ACT_READ, 6'd0, $urandom(), $urandom());
      send_request(prs_pkg::ACT_READ, 6'd63, $urandom(), $urandom());
   endtask

   task automatic test_shuffle_corners();
      set_shuffle_config(7'd4, 7'd4);
      send_request(prs_pkg::ACT_RESTART, 6'd0, 32'h0, 32'h0);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'h0000_0000);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'hFFFF_FFFF);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'h0000_0001);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'h0000_0002);
      // finished, nothing left to do
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, $urandom());
      send_request(prs_pkg::ACT_READ, 6'd0, 32'h0, 32'h0);
      send_request(prs_pkg::ACT_READ, 6'd1, 32'h0, 32'h0);
      send_request(prs_pkg::ACT_READ, 6'd2, 32'h0, 32'h0);
      // pick count lowered in mid-shuffle
      send_request(prs_pkg::ACT_RESTART, 6'd0, 32'h0, 32'h0);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'h0);
      set_shuffle_config(7'd4, 7'd1);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, $urandom());
      // oversized size and pick count saturate
      set_shuffle_config(7'd127, 7'd127);
      send_request(prs_pkg::ACT_RESTART, 6'd0, 32'h0, 32'h0);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'hFFFF_FFC0);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, 32'h0000_003F);
      set_shuffle_config(7'd0, 7'd64);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, $urandom());
      set_shuffle_config(7'd1, 7'd0);
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, $urandom());
      set_shuffle_config(7'd64, 7'd10);
      send_request(prs_pkg::ACT_RESTART, 6'd63, $urandom(), $urandom());
      send_request(prs_pkg::ACT_RANDOM, 6'd0, 32'h0, $urandom());
      send_request(prs_pkg::ACT_LOAD, 6'd63, 32'hA5A5_5A5A, $urandom());
      send_request(prs_pkg::ACT_READ, 6'd63, 32'h0, 32'h0);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall);
      int          target;
      int          guard;
      int unsigned top_index;
      drain_responses();
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) begin
         if ($urandom_range(9) < 3) pick_random_config();
         if ($urandom_range(9) < 8)
            send_request(prs_pkg::ACT_RESTART, 6'($urandom_range(63)), $urandom(),
                         $urandom());
         guard = 0;
         while (!shuffle_finished() && guard < 300) begin
            case ($urandom_range(19))
               0: send_noise();
               1: send_request(prs_pkg::ACT_LOAD, 6'($urandom_range(63)), $urandom(),
                               $urandom());
               default: send_request(prs_pkg::ACT_RANDOM, 6'($urandom_range(63)),
                                     $urandom(), $urandom());
            endcase
            guard++;
         end
         if ($urandom_range(3) == 0)
            send_request(prs_pkg::ACT_RANDOM, 6'($urandom_range(63)), $urandom(),
                         $urandom());
         top_index = (active_size() > 0) ? active_size() - 1 : 0;
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 0)
               send_request(prs_pkg::ACT_READ, 6'($urandom_range(top_index)), $urandom(),
                            $urandom());
            else
               send_request(prs_pkg::ACT_READ, 6'($urandom_range(63)), $urandom(),
                            $urandom());
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      shuffle_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with none pending: status %0d data %h",
                        rsp_tuser, rsp_tdata);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[31:0] !== want.read_value ||
                rsp_tdata[38:32] !== want.step_position ||
                rsp_tdata[39] !== want.shuffle_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d value %h step %0d done %0d,",
                           want.status, want.read_value, want.step_position,
                           want.shuffle_done,
                           " got status %0d value %h step %0d done %0d",
                           rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32], rsp_tdata[39]);
            end
            status_seen[int'(want.status)]++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** partial_random_shuffle: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_fill_store();
      test_shuffle_corners();
      test_random_traffic(0, 0);
      test_random_traffic(82, 0);
      test_random_traffic(0, 82);
      test_random_traffic(8, 8);
      drain_responses();
      repeat (10) @(posedge clock);
      $display("%0d requests, %0d csr writes: %0d loads, %0d swaps, %0d rejected words",
               requests_sent, csr_writes, status_seen[prs_pkg::RSP_LOADED],
               status_seen[prs_pkg::RSP_SWAPPED], status_seen[prs_pkg::RSP_REJECTED]);
      $display("%0d idle words, %0d reads, %0d restarts, %0d mismatches",
               status_seen[prs_pkg::RSP_IDLE], status_seen[prs_pkg::RSP_READ],
               status_seen[prs_pkg::RSP_RESTARTED], mismatches);
      if (mismatches == 0) begin
         $display("** partial_random_shuffle: PASSED **");
      end else begin
         $display("** partial_random_shuffle: FAILED **");
      end
      $finish;
   end

endmodule
